FILE: hw/rtl/nirpd_pkg.sv
// Shared types and constants for the NEC IR pulse decoder.
// Holds the item structs, the command and capture codes, and the NEC timing limits.
// No dependencies; every other file of the decoder imports this package.
`timescale 1ns / 1ps
`default_nettype none

package nirpd_pkg;

	localparam int TS_W            = 32;
	localparam int SCALE_W         = 12;
	localparam int PROD_W          = TS_W + SCALE_W;
	localparam int TD_W            = 16;
	localparam int BITCNT_W        = 6;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [SCALE_W-1:0] TIME_SCALE_RESET = 12'd4;

	// Command codes of an input item.
	localparam logic [1:0] CMD_EDGE = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	// Capture status codes.
	localparam logic [1:0] ST_NONE    = 2'd0;
	localparam logic [1:0] ST_REPEAT  = 2'd1;
	localparam logic [1:0] ST_MESSAGE = 2'd2;

	// Pulse widths in microseconds.
	localparam logic [TD_W-1:0] TD_SAT           = 16'd65535;
	localparam logic [TD_W-1:0] TD_RESYNC        = 16'd30000;
	localparam logic [TD_W-1:0] TD_TICK_TIMEOUT  = 16'd10000;
	localparam logic [TD_W-1:0] TD_MARK_TIMEOUT  = 16'd11000;
	localparam logic [TD_W-1:0] TD_REP_SPACE_MIN = 16'd2000;
	localparam logic [TD_W-1:0] TD_REP_SPACE_MAX = 16'd2500;
	localparam logic [TD_W-1:0] TD_HDR_SPACE_MIN = 16'd4000;
	localparam logic [TD_W-1:0] TD_HDR_SPACE_MAX = 16'd5000;
	localparam logic [TD_W-1:0] TD_BIT_MIN       = 16'd400;
	localparam logic [TD_W-1:0] TD_BIT_MAX       = 16'd1880;
	localparam logic [TD_W-1:0] TD_BIT_GAP_LO    = 16'd800;
	localparam logic [TD_W-1:0] TD_BIT_GAP_HI    = 16'd1400;
	localparam logic [TD_W-1:0] TD_BIT_ONE       = 16'd1000;
	localparam logic [TD_W-1:0] TD_MARK_MIN      = 16'd300;
	localparam logic [TD_W-1:0] TD_MARK_MAX      = 16'd950;

	// The repeat window is 2^18 us, so a delta below it has its upper bits clear.
	localparam int REPEAT_WIN_LOG2 = 18;

	localparam logic [BITCNT_W-1:0] BITS_PER_MSG = 6'd32;

	typedef struct packed {
		logic [1:0]      command;
		logic            pin_level;
		logic [TS_W-1:0] timestamp;
	} evt_t;

	typedef struct packed {
		logic [1:0]      capture_status;
		logic [TS_W-1:0] capture_word;
	} res_t;

	typedef enum logic [2:0] {
		KIND_NOP,
		KIND_READ,
		KIND_TICK,
		KIND_RISE,
		KIND_FALL
	} kind_t;

	typedef struct packed {
		kind_t           kind;
		logic [TS_W-1:0] diff;
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LEADER,
		PH_DATA
	} phase_t;

endpackage

`default_nettype wire

FILE: hw/rtl/nirpd_front.sv
// Front end of the NEC IR pulse decoder: accepts input items and classifies them.
// Tracks the pin level and last edge time and forwards the tick difference.
// Depends on nirpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nirpd_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              evt_valid,
	output logic             evt_stall,
	input  nirpd_pkg::evt_t  evt,
	input  wire              q_full,
	output logic             push,
	output nirpd_pkg::cmd_t  push_cmd
);
	import nirpd_pkg::*;

	logic            last_level_q;
	logic [TS_W-1:0] last_edge_time_q;
	logic            edge_changed;

	assign evt_stall    = q_full;
	assign push         = evt_valid && !q_full;
	assign edge_changed = (evt.command == CMD_EDGE) && (evt.pin_level != last_level_q);

	always_comb begin
		push_cmd.diff = evt.timestamp - last_edge_time_q;
		case (evt.command)
			CMD_READ: push_cmd.kind = KIND_READ;
			CMD_TICK: push_cmd.kind = KIND_TICK;
			CMD_EDGE: begin
				// An edge that repeats the current level carries no timing.
				if (!edge_changed)
					push_cmd.kind = KIND_NOP;
				else if (evt.pin_level)
					push_cmd.kind = KIND_RISE;
				else
					push_cmd.kind = KIND_FALL;
			end
			default: push_cmd.kind = KIND_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q     <= 1'b1;
			last_edge_time_q <= '0;
		end else if (push && edge_changed) begin
			last_level_q     <= evt.pin_level;
			last_edge_time_q <= evt.timestamp;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/nirpd_queue.sv
// Short first-in first-out queue between the decoder front and back ends.
// Holds classified items so either side can stall on its own.
// Depends on nirpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nirpd_queue #(
	parameter int unsigned DEPTH = nirpd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  nirpd_pkg::cmd_t  push_cmd,
	output logic             full,
	input  wire              pop,
	output logic             pop_valid,
	output nirpd_pkg::cmd_t  pop_cmd
);
	import nirpd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd   = slots_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
		ptr_next = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/nirpd_back.sv
// Back end of the NEC IR pulse decoder: scales the time, runs the frame tracker
// and produces one result item per classified item through an output register.
// Depends on nirpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nirpd_back (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_wr_en,
	input  wire [nirpd_pkg::SCALE_W-1:0]  cfg_wr_data,
	input  wire                           q_valid,
	input  nirpd_pkg::cmd_t               q_cmd,
	output logic                          pop,
	output logic                          res_valid,
	input  wire                           res_stall,
	output nirpd_pkg::res_t               res
);
	import nirpd_pkg::*;

	logic [SCALE_W-1:0]  time_scale_q;

	// Stage 1: scaled time.
	logic                s1_valid_q;
	kind_t               kind_s1;
	logic [PROD_W-1:0]   scaled_s1;

	// Decoder state.
	phase_t              phase_q;
	logic [BITCNT_W-1:0] bit_count_q;
	logic [TS_W-1:0]     shift_word_q;
	logic [TS_W-1:0]     elapsed_sum_q;
	logic [TS_W-1:0]     last_msg_q;
	logic [TS_W-1:0]     held_word_q;
	logic [1:0]          held_status_q;

	phase_t              phase_d;
	logic [BITCNT_W-1:0] bit_count_d;
	logic [TS_W-1:0]     shift_word_d;
	logic [TS_W-1:0]     elapsed_sum_d;
	logic [TS_W-1:0]     last_msg_d;
	logic [TS_W-1:0]     held_word_d;
	logic [1:0]          held_status_d;

	logic                res_valid_q;
	res_t                res_q;
	res_t                res_d;
	logic                commit;

	logic [TD_W-1:0]     td;
	logic [TS_W-1:0]     sum_new;
	logic [TS_W-1:0]     rep_delta;
	logic [4:0]          bit_pos;
	logic [TS_W-1:0]     shift_set;
	logic [BITCNT_W-1:0] bit_count_inc;

	assign commit = s1_valid_q && (!res_valid_q || !res_stall);
	assign pop    = q_valid && (!s1_valid_q || commit);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign td        = (|scaled_s1[PROD_W-1:TD_W]) ? TD_SAT : scaled_s1[TD_W-1:0];
	assign sum_new   = elapsed_sum_q + scaled_s1[TS_W-1:0];
	assign rep_delta = sum_new - last_msg_q;
	// Message bits 0-15 land in word positions 16-31, bits 16-31 in positions 0-15.
	assign bit_pos       = ~(bit_count_q[4:0] ^ 5'd15);
	assign shift_set     = shift_word_q | (TS_W'(1) << bit_pos);
	assign bit_count_inc = bit_count_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_scale_q <= TIME_SCALE_RESET;
		end else if (cfg_wr_en) begin
			time_scale_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pop) begin
			s1_valid_q <= 1'b1;
		end else if (commit) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1   <= q_cmd.kind;
			scaled_s1 <= PROD_W'(q_cmd.diff) * PROD_W'(time_scale_q);
		end
	end

	// Next state of the frame tracker and the capture holder.
	always_comb begin
		phase_d       = phase_q;
		bit_count_d   = bit_count_q;
		shift_word_d  = shift_word_q;
		elapsed_sum_d = elapsed_sum_q;
		last_msg_d    = last_msg_q;
		held_word_d   = held_word_q;
		held_status_d = held_status_q;
		case (kind_s1)
			KIND_READ: begin
				held_word_d   = '0;
				held_status_d = ST_NONE;
			end
			KIND_TICK: begin
				// A tick while idle is dropped without touching the running sum.
				if (phase_q != PH_IDLE) begin
					elapsed_sum_d = sum_new;
					if (td > TD_TICK_TIMEOUT)
						phase_d = PH_IDLE;
				end
			end
			KIND_RISE: begin
				elapsed_sum_d = sum_new;
				if (td > TD_MARK_TIMEOUT ||
				    (phase_q == PH_DATA && (td < TD_MARK_MIN || td > TD_MARK_MAX)))
					phase_d = PH_IDLE;
			end
			KIND_FALL: begin
				elapsed_sum_d = sum_new;
				if (phase_q == PH_IDLE || td >= TD_RESYNC) begin
					phase_d     = PH_LEADER;
					bit_count_d = '0;
				end else if (phase_q == PH_LEADER) begin
					if (td > TD_REP_SPACE_MIN && td < TD_REP_SPACE_MAX) begin
						// Short leader space: a repeat code, only near the last message.
						if (last_msg_q != '0) begin
							if (rep_delta[TS_W-1:REPEAT_WIN_LOG2] == '0) begin
								if (held_status_q == ST_NONE) begin
									held_status_d = ST_REPEAT;
									held_word_d   = TS_W'(1);
								end
								last_msg_d = sum_new;
							end else begin
								last_msg_d = '0;
							end
						end
					end else if (td < TD_HDR_SPACE_MIN || td > TD_HDR_SPACE_MAX) begin
						phase_d = PH_IDLE;
					end else begin
						phase_d      = PH_DATA;
						shift_word_d = '0;
					end
				end else if (phase_q != PH_DATA) begin
					phase_d = PH_IDLE;
				end else if (td < TD_BIT_MIN || td > TD_BIT_MAX) begin
					phase_d = PH_IDLE;
				end else if (td > TD_BIT_GAP_LO && td < TD_BIT_GAP_HI) begin
					phase_d = PH_IDLE;
				end else if (bit_count_q < BITS_PER_MSG) begin
					bit_count_d = bit_count_inc;
					if (bit_count_inc == BITS_PER_MSG) begin
						held_word_d   = (td > TD_BIT_ONE) ? shift_set : shift_word_q;
						held_status_d = ST_MESSAGE;
						last_msg_d    = sum_new;
						shift_word_d  = '0;
						phase_d       = PH_IDLE;
					end else if (td > TD_BIT_ONE) begin
						shift_word_d = shift_set;
					end
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// Result of the item in stage 1: only a read returns a capture.
	always_comb begin
		res_d = '0;
		if (kind_s1 == KIND_READ) begin
			res_d.capture_status = held_status_q;
			res_d.capture_word   = (held_status_q != ST_NONE) ? held_word_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bit_count_q   <= '0;
			shift_word_q  <= '0;
			elapsed_sum_q <= '0;
			last_msg_q    <= '0;
			held_word_q   <= '0;
			held_status_q <= ST_NONE;
		end else if (commit) begin
			phase_q       <= phase_d;
			bit_count_q   <= bit_count_d;
			shift_word_q  <= shift_word_d;
			elapsed_sum_q <= elapsed_sum_d;
			last_msg_q    <= last_msg_d;
			held_word_q   <= held_word_d;
			held_status_q <= held_status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (commit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit)
			res_q <= res_d;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/nec_ir_pulse_decoder.sv
// NEC IR pulse decoder, top level.
// Connects the front end, the item queue and the back end; depends on nirpd_pkg.
//
// Usage:
//   Input channel evt_valid / evt_stall / evt carries pin edges, timer ticks and
//   read-and-clear commands with a 32-bit tick timestamp. Every accepted item
//   yields exactly one result item on res_valid / res_stall / res; only a read
//   returns the held capture (status and word), all other items return zeros.
//   cfg_wr_en / cfg_wr_data write the 12-bit tick-to-microsecond multiplier;
//   write it only while no item is in flight.
//   Path: the accepting edge writes the queue, then the scaling multiply is
//   registered in stage 1, then the state update goes into the output register,
//   where the result is first offered.
//   Throughput: one item per cycle while res_stall stays low, set by the state
//   update loop in the back end; the two-entry queue keeps the front running
//   while the back end waits.
//   Reset: the multiplier returns to 4, the pin is taken as idle high, and all
//   frame, timing and capture state clears at once; items are taken right away.
//   Stall: a stalled result holds in the output register while the next item
//   waits in the scaling stage; once the queue fills, evt_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module nec_ir_pulse_decoder #(
	parameter int unsigned QUEUE_DEPTH = nirpd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_wr_en,
	input  wire [nirpd_pkg::SCALE_W-1:0]  cfg_wr_data,
	input  wire                           evt_valid,
	output logic                          evt_stall,
	input  nirpd_pkg::evt_t               evt,
	output logic                          res_valid,
	input  wire                           res_stall,
	output nirpd_pkg::res_t               res
);
	import nirpd_pkg::*;

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic pop;
	logic q_valid;
	cmd_t q_cmd;

	nirpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	nirpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_cmd   (q_cmd)
	);

	nirpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_valid     (q_valid),
		.q_cmd       (q_cmd),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res)
	);

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the NEC IR pulse decoder (nec_ir_pulse_decoder).
// A scoreboard class predicts every result item from the accepted input items.
// Random NEC frames, repeat codes and noise run under several time scales; needs nirpd_pkg.
`timescale 1ns / 1ps

module testbench;
	import nirpd_pkg::*;

	localparam logic [1:0] CMD_NOP         = 2'd3;
	localparam int         CYCLE_LIMIT     = 300000;
	localparam int         ITEMS_PER_PHASE = 100;
	localparam int         PHASES          = 6;

	// Nominal NEC timing in microseconds.
	localparam int unsigned FRAME_GAP_US    = 40000;
	localparam int unsigned LEADER_MARK_US  = 9000;
	localparam int unsigned LEADER_SPACE_US = 4500;
	localparam int unsigned REPEAT_SPACE_US = 2250;
	localparam int unsigned BIT_MARK_US     = 560;
	localparam int unsigned ZERO_SPACE_US   = 560;
	localparam int unsigned ONE_SPACE_US    = 1690;

	// Durations on and around every decision threshold of the decoder.
	localparam int unsigned LIMIT_US[31] = '{
		299, 300, 301, 399, 400, 800, 801, 950, 951, 1000, 1001, 1399, 1400, 1880, 1881,
		2000, 2001, 2499, 2500, 3999, 4000, 5000, 5001, 10000, 10001, 11000, 11001,
		29999, 30000, 65535, 200000
	};

	localparam logic [SCALE_W-1:0] SCALE_PLAN[PHASES] = '{12'd4, 12'd1, 12'd4095, 12'd0,
		12'd4000, 12'd13};

	class capture_scoreboard;
		logic [SCALE_W-1:0] scale;
		phase_t             phase;
		logic [5:0]         bits_done;
		logic [31:0]        shift_acc;
		logic [31:0]        edge_ts;
		logic [31:0]        run_sum;
		logic [31:0]        msg_sum;
		logic [31:0]        held_word;
		logic [1:0]         held_status;
		logic               level_now;
		res_t               expected_q[$];
		int                 errors;
		int                 checked;
		int                 messages;
		int                 repeats;

		function new();
			scale       = TIME_SCALE_RESET;
			phase       = PH_IDLE;
			bits_done   = '0;
			shift_acc   = '0;
			edge_ts     = '0;
			run_sum     = '0;
			msg_sum     = '0;
			held_word   = '0;
			held_status = ST_NONE;
			level_now   = 1'b1;
			errors      = 0;
			checked     = 0;
			messages    = 0;
			repeats     = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Advances the decoder state by one accepted item and queues its result.
		function void note_event(evt_t e);
			res_t        want;
			logic [31:0] diff;
			logic [31:0] gap;
			logic [63:0] scaled;
			logic [15:0] td;
			logic [4:0]  pos;
			logic        live;

			want = '0;
			live = 1'b0;
			case (e.command)
				CMD_READ: begin
					want.capture_status = held_status;
					want.capture_word   = (held_status != ST_NONE) ? held_word : '0;
					held_status         = ST_NONE;
					held_word           = '0;
				end
				CMD_EDGE: begin
					if (e.pin_level != level_now) begin
						level_now = e.pin_level;
						live      = 1'b1;
					end
				end
				CMD_TICK: live = (phase != PH_IDLE);
				default: live = 1'b0;
			endcase

			if (live) begin
				diff   = e.timestamp - edge_ts;
				scaled = {32'd0, diff} * {52'd0, scale};
				td     = (scaled > {48'd0, TD_SAT}) ? TD_SAT : scaled[15:0];
				if (e.command == CMD_EDGE)
					edge_ts = e.timestamp;
				run_sum = run_sum + scaled[31:0];

				if (e.command == CMD_TICK) begin
					if (td > TD_TICK_TIMEOUT)
						phase = PH_IDLE;
				end else if (e.pin_level) begin
					if (td > TD_MARK_TIMEOUT)
						phase = PH_IDLE;
					if (phase == PH_DATA && (td < TD_MARK_MIN || td > TD_MARK_MAX))
						phase = PH_IDLE;
				end else if (phase == PH_IDLE || td >= TD_RESYNC) begin
					phase     = PH_LEADER;
					bits_done = '0;
				end else if (phase == PH_LEADER) begin
					if (td > TD_REP_SPACE_MIN && td < TD_REP_SPACE_MAX) begin
						// A repeat only counts close enough after a message or repeat.
						gap = run_sum - msg_sum;
						if (msg_sum != 0) begin
							if (gap < (32'd1 << REPEAT_WIN_LOG2)) begin
								if (held_status == ST_NONE) begin
									held_status = ST_REPEAT;
									held_word   = 32'd1;
								end
								msg_sum = run_sum;
							end else begin
								msg_sum = '0;
							end
						end
					end else if (td < TD_HDR_SPACE_MIN || td > TD_HDR_SPACE_MAX) begin
						phase = PH_IDLE;
					end else begin
						phase     = PH_DATA;
						shift_acc = '0;
					end
				end else if (phase != PH_DATA) begin
					phase = PH_IDLE;
				end else if (td < TD_BIT_MIN || td > TD_BIT_MAX) begin
					phase = PH_IDLE;
				end else if (td > TD_BIT_GAP_LO && td < TD_BIT_GAP_HI) begin
					phase = PH_IDLE;
				end else if (bits_done < BITS_PER_MSG) begin
					// Bits 0-15 land in positions 16-31 and bits 16-31 in positions 0-15.
					pos = bits_done[4:0] ^ 5'd16;
					if (td > TD_BIT_ONE)
						shift_acc[pos] = 1'b1;
					bits_done = bits_done + 6'd1;
					if (bits_done == BITS_PER_MSG) begin
						held_word   = shift_acc;
						held_status = ST_MESSAGE;
						msg_sum     = run_sum;
						shift_acc   = '0;
						phase       = PH_IDLE;
					end
				end
			end
			expected_q.push_back(want);
		endfunction

		function void check_result(res_t got);
			res_t want;

			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result item with none expected, expected nothing, got %h",
					$time, got);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.capture_status !== want.capture_status) begin
				errors++;
				$display("%0t: capture_status expected %0d, got %0d", $time,
					want.capture_status, got.capture_status);
			end
			if (got.capture_word !== want.capture_word) begin
				errors++;
				$display("%0t: capture_word expected %h, got %h", $time,
					want.capture_word, got.capture_word);
			end
			if (want.capture_status == ST_MESSAGE)
				messages++;
			if (want.capture_status == ST_REPEAT)
				repeats++;
		endfunction
	endclass

	logic               clk;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic [SCALE_W-1:0] cfg_wr_data = '0;
	logic               evt_valid   = 1'b0;
	logic               evt_stall;
	evt_t               evt         = '0;
	logic               res_valid;
	logic               res_stall   = 1'b0;
	res_t               res;

	capture_scoreboard  sb;
	evt_t               plan_q[$];
	logic [31:0]        now_ticks;
	logic               plan_level;
	logic [SCALE_W-1:0] stim_scale  = TIME_SCALE_RESET;
	int                 send_idle_pct;
	int                 recv_idle_pct;
	int                 cycle_count = 0;

	nec_ir_pulse_decoder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.evt_valid   (evt_valid),
		.evt_stall   (evt_stall),
		.evt         (evt),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(res);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d result items outstanding.",
				cycle_count, sb.pending());
			$display("nec_ir_pulse_decoder verification failed");
			$finish;
		end
	end

	function automatic int unsigned pick_us(int unsigned nominal);
		if ($urandom_range(0, 199) == 0)
			return LIMIT_US[$urandom_range(0, 30)];
		return nominal - nominal / 10 + $urandom_range(0, nominal / 5);
	endfunction

	function automatic logic [31:0] ticks_for(int unsigned us);
		if (stim_scale == 0)
			return $urandom_range(0, 4000);
		return us / stim_scale;
	endfunction

	function automatic void push_edge(logic lvl, int unsigned nominal);
		now_ticks  = now_ticks + ticks_for(pick_us(nominal));
		plan_level = lvl;
		plan_q.push_back(evt_t'{CMD_EDGE, lvl, now_ticks});
	endfunction

	function automatic void push_read();
		plan_q.push_back(evt_t'{CMD_READ, 1'($urandom_range(0, 1)), 32'($urandom)});
	endfunction

	function automatic void add_repeat();
		if (!plan_level)
			push_edge(1'b1, BIT_MARK_US);
		push_edge(1'b0, FRAME_GAP_US);
		push_edge(1'b1, LEADER_MARK_US);
		push_edge(1'b0, REPEAT_SPACE_US);
		push_edge(1'b1, BIT_MARK_US);
	endfunction

	// Mostly complete frames with random data, plus repeats, reads and noise.
	function automatic void build_plan(int target);
		int          choice;
		logic [1:0]  cmd_code;
		logic        lvl;
		logic [31:0] ts;

		while (plan_q.size() < target) begin
			choice = $urandom_range(0, 99);
			if (choice < 50) begin
				if (!plan_level)
					push_edge(1'b1, BIT_MARK_US);
				push_edge(1'b0, FRAME_GAP_US);
				push_edge(1'b1, LEADER_MARK_US);
				push_edge(1'b0, LEADER_SPACE_US);
				for (int b = 0; b < 32; b++) begin
					push_edge(1'b1, BIT_MARK_US);
					if ($urandom_range(0, 39) == 0)
						plan_q.push_back(evt_t'{CMD_TICK, 1'($urandom_range(0, 1)),
							now_ticks + ticks_for(pick_us(200))});
					push_edge(1'b0, $urandom_range(0, 1) ? ONE_SPACE_US : ZERO_SPACE_US);
				end
				push_edge(1'b1, BIT_MARK_US);
				repeat ($urandom_range(0, 3)) add_repeat();
				if ($urandom_range(0, 9) < 7)
					push_read();
			end else if (choice < 65) begin
				add_repeat();
			end else if (choice < 80) begin
				push_read();
			end else begin
				repeat ($urandom_range(1, 4)) begin
					cmd_code = 2'($urandom_range(0, 3));
					lvl      = 1'($urandom_range(0, 1));
					ts       = ($urandom_range(0, 3) == 0) ? 32'($urandom)
						: now_ticks + $urandom_range(0, 5000);
					if (cmd_code == CMD_EDGE && lvl != plan_level) begin
						now_ticks  = ts;
						plan_level = lvl;
					end
					plan_q.push_back(evt_t'{cmd_code, lvl, ts});
				end
			end
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(evt_t e);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			evt_valid <= 1'b0;
			@(negedge clk);
		end
		evt_valid <= 1'b1;
		evt       <= e;
		do @(posedge clk); while (evt_stall);
		sb.note_event(e);
		@(negedge clk);
	endtask

	task automatic drain();
		evt_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_scale(logic [SCALE_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		stim_scale  = value;
		sb.scale    = value;
	endtask

	task automatic send_plan();
		int hold_at;

		hold_at = $urandom_range(0, plan_q.size() - 1);
		for (int i = 0; plan_q.size() != 0; i++) begin
			if (i == hold_at)
				drain();
			send_item(plan_q.pop_front());
		end
	endtask

	initial begin
		logic [31:0] t;

		sb            = new();
		send_idle_pct = 10;
		recv_idle_pct = 46;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Short directed sequence at the reset time scale.
		plan_q.push_back(evt_t'{CMD_READ, 1'b1, 32'hFFFF_FFFF});
		plan_q.push_back(evt_t'{CMD_NOP, 1'b0, 32'h0000_0000});
		plan_q.push_back(evt_t'{CMD_EDGE, 1'b1, 32'h0000_0000});
		plan_q.push_back(evt_t'{CMD_TICK, 1'b0, 32'h1234_5678});
		t = 32'hFFFF_FFF0;
		plan_q.push_back(evt_t'{CMD_EDGE, 1'b0, t});
		t = t + 2250;
		plan_q.push_back(evt_t'{CMD_EDGE, 1'b1, t});
		t = t + 1125;
		plan_q.push_back(evt_t'{CMD_EDGE, 1'b0, t});
		t = t + 140;
		plan_q.push_back(evt_t'{CMD_EDGE, 1'b1, t});
		t = t + 422;
		plan_q.push_back(evt_t'{CMD_EDGE, 1'b0, t});
		t = t + 140;
		plan_q.push_back(evt_t'{CMD_EDGE, 1'b1, t});
		t = t + 140;
		plan_q.push_back(evt_t'{CMD_EDGE, 1'b0, t});
		t = t + 140;
		plan_q.push_back(evt_t'{CMD_EDGE, 1'b1, t});
		plan_q.push_back(evt_t'{CMD_TICK, 1'b1, t + 3000});
		t = t + 20000;
		plan_q.push_back(evt_t'{CMD_EDGE, 1'b0, t});
		t = t + 2250;
		plan_q.push_back(evt_t'{CMD_EDGE, 1'b1, t});
		// Repeat spacing with no earlier message leaves the capture empty.
		t = t + 562;
		plan_q.push_back(evt_t'{CMD_EDGE, 1'b0, t});
		t = t + 300;
		plan_q.push_back(evt_t'{CMD_EDGE, 1'b1, t});
		t = t + 7500;
		plan_q.push_back(evt_t'{CMD_EDGE, 1'b0, t});
		t = t + 3000;
		plan_q.push_back(evt_t'{CMD_EDGE, 1'b1, t});
		plan_q.push_back(evt_t'{CMD_READ, 1'b0, 32'h0000_0000});
		send_plan();

		now_ticks  = $urandom;
		plan_level = 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_scale(SCALE_PLAN[p]);
			case (p / 2)
				0: begin
					send_idle_pct = 10;
					recv_idle_pct = 46;
				end
				1: begin
					send_idle_pct = 46;
					recv_idle_pct = 10;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			build_plan(ITEMS_PER_PHASE);
			send_plan();
		end

		drain();
		repeat (8) @(negedge clk);
		$display("%0d result items compared; %0d messages and %0d repeat codes read back.",
			sb.checked, sb.messages, sb.repeats);
		$display("Covered %0d time scales from 0 to 4095 under three stall patterns.", PHASES);
		if (sb.errors == 0) begin
			$display("nec_ir_pulse_decoder verification clean");
		end else begin
			$display("nec_ir_pulse_decoder verification failed");
		end
		$finish;
	end

endmodule
